[rtl/core/tmi_pkg.sv]
// shared types and constants of the tape machine interpreter
package tmi_pkg;

	localparam int DEF_PROG_DEPTH  = 4096;
	localparam int DEF_TAPE_DEPTH  = 1024;
	localparam int DEF_INPUT_DEPTH = 256;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 13;
	localparam int ADDR_W = 12;
	localparam int KIND_W = 2;

	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
	localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
	localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_LBR   = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_RBR   = 8'h5D;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD    = 2'd0,
		KIND_APPEND  = 2'd1,
		KIND_STEP    = 2'd2,
		KIND_RESTART = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_DECODE,
		S_TREAD,
		S_IREAD,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_RESP
	} state_t;

endpackage

[rtl/core/tape_machine_interpreter_top.sv]
// top level of the tape machine interpreter: sequencer and memories
// Eight-command tape machine with 8-bit cells. Each input beat loads a program
// character, appends an input byte, executes one instruction or restarts; each
// gives exactly one result beat. One item is worked on at a time, and a new one
// is taken while the last result still waits. Program, tape and input buffer
// each sit in a single-port ram with one access per cycle. A load passes
// through the address reduction when PROG_DEPTH is not a power of two below
// 4096; moves and input reads add a read of the tape or input buffer; a
// bracket skip reads in turn each program character that it looks at. Restart
// clears the tape one cell a cycle. After reset the same clear runs before the
// first beat is taken; configuration writes are taken at any time.
module tape_machine_interpreter_top #(
	parameter int PROG_DEPTH  = tmi_pkg::DEF_PROG_DEPTH,
	parameter int TAPE_DEPTH  = tmi_pkg::DEF_TAPE_DEPTH,
	parameter int INPUT_DEPTH = tmi_pkg::DEF_INPUT_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_we,
	input  logic [tmi_pkg::LEN_W-1:0]    cfg_wdata,
	// input channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [tmi_pkg::KIND_W-1:0]   kind,
	input  logic [tmi_pkg::ADDR_W-1:0]   prog_addr,
	input  logic [tmi_pkg::BYTE_W-1:0]   prog_char,
	input  logic [tmi_pkg::BYTE_W-1:0]   in_byte,
	// result channel
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic                         out_valid,
	output logic [tmi_pkg::BYTE_W-1:0]   out_byte,
	output logic [tmi_pkg::LEN_W-1:0]    pc_now,
	output logic [tmi_pkg::BYTE_W-1:0]   cell_now,
	output logic                         halted,
	output logic                         buffer_full
);

	localparam int BW  = tmi_pkg::BYTE_W;
	localparam int PW  = tmi_pkg::LEN_W;
	localparam int PAW = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
	localparam int TW  = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
	localparam int IAW = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
	localparam int IFW = $clog2(INPUT_DEPTH + 1);
	// wide enough for the length register and the program depth
	localparam int LW  = ($clog2(PROG_DEPTH + 1) > PW) ? $clog2(PROG_DEPTH + 1) : PW;

	tmi_pkg::state_t state_q, state_d;

	// architectural state
	logic [PW-1:0]  len_q;
	logic [PW-1:0]  pc_q, pc_d;
	logic [TW-1:0]  tp_q, tp_d;
	logic [IFW-1:0] idx_q, idx_d;
	logic [IFW-1:0] fill_q, fill_d;
	logic [BW-1:0]  cell_q, cell_d;   // mirror of tape[tp]

	// per-item working state
	logic [PW-1:0]  scan_q, scan_d;   // scan position
	logic [PW-1:0]  depth_q, depth_d; // bracket nesting during a skip
	logic           fwd_q, fwd_d;
	logic           emit_q, emit_d;
	logic           full_q, full_d;
	logic           clr_resp_q, clr_resp_d;
	logic [TW-1:0]  clr_q, clr_d;
	logic           mod_go_q, mod_go_d;
	logic [tmi_pkg::ADDR_W-1:0] addr_q;
	logic [BW-1:0]  pchar_q;

	// result register
	logic           res_valid_q;
	logic           out_valid_q;
	logic [BW-1:0]  out_byte_q;
	logic [PW-1:0]  pc_now_q;
	logic [BW-1:0]  cell_now_q;
	logic           halted_q;
	logic           full_out_q;

	// memory ports
	logic           p_we, t_we, i_we;
	logic [PAW-1:0] p_addr;
	logic [TW-1:0]  t_addr;
	logic [IAW-1:0] i_addr;
	logic [BW-1:0]  p_wdata, t_wdata, i_wdata;
	logic [BW-1:0]  p_rdata, t_rdata, i_rdata;

	logic           mod_done;
	logic [PAW-1:0] mod_res;

	logic [LW-1:0]  eff_len;
	logic           pc_halted;
	logic           in_beat;
	logic           res_load;
	logic           slot_free;
	logic [TW-1:0]  tp_inc, tp_dec;
	tmi_pkg::kind_t in_kind;

	assign in_kind   = tmi_pkg::kind_t'(kind);
	assign in_ready  = (state_q == tmi_pkg::S_IDLE);
	assign in_beat   = in_valid && in_ready;
	assign slot_free = !res_valid_q || res_ready;
	assign res_load  = (state_q == tmi_pkg::S_RESP) && slot_free;

	// effective length is the smaller of the register and the program depth
	assign eff_len   = (LW'(len_q) < LW'(PROG_DEPTH)) ? LW'(len_q) : LW'(PROG_DEPTH);
	assign pc_halted = LW'(pc_q) >= eff_len;

	// tape pointer wraps round the tape
	assign tp_inc = (tp_q == TW'(TAPE_DEPTH - 1)) ? '0 : tp_q + 1'b1;
	assign tp_dec = (tp_q == '0) ? TW'(TAPE_DEPTH - 1) : tp_q - 1'b1;

	tmi_ram #(.WIDTH(BW), .DEPTH(PROG_DEPTH)) u_prog_ram (
		.clk   (clk),
		.we    (p_we),
		.addr  (p_addr),
		.wdata (p_wdata),
		.rdata (p_rdata)
	);

	tmi_ram #(.WIDTH(BW), .DEPTH(TAPE_DEPTH)) u_tape_ram (
		.clk   (clk),
		.we    (t_we),
		.addr  (t_addr),
		.wdata (t_wdata),
		.rdata (t_rdata)
	);

	tmi_ram #(.WIDTH(BW), .DEPTH(INPUT_DEPTH)) u_input_ram (
		.clk   (clk),
		.we    (i_we),
		.addr  (i_addr),
		.wdata (i_wdata),
		.rdata (i_rdata)
	);

	tmi_addr_mod #(.DEPTH(PROG_DEPTH)) u_addr_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_go_q),
		.addr   (addr_q),
		.done   (mod_done),
		.res    (mod_res)
	);

	// next state, datapath and memory control
	always_comb begin
		state_d    = state_q;
		pc_d       = pc_q;
		tp_d       = tp_q;
		idx_d      = idx_q;
		fill_d     = fill_q;
		cell_d     = cell_q;
		scan_d     = scan_q;
		depth_d    = depth_q;
		fwd_d      = fwd_q;
		emit_d     = emit_q;
		full_d     = full_q;
		clr_resp_d = clr_resp_q;
		clr_d      = clr_q;
		mod_go_d   = 1'b0;

		p_we    = 1'b0;
		p_addr  = PAW'(pc_q);
		p_wdata = pchar_q;
		t_we    = 1'b0;
		t_addr  = tp_q;
		t_wdata = cell_q;
		i_we    = 1'b0;
		i_addr  = IAW'(fill_q);
		i_wdata = in_byte;

		unique case (state_q)
			tmi_pkg::S_CLEAR: begin
				// zero the tape one cell a cycle
				t_we    = 1'b1;
				t_addr  = clr_q;
				t_wdata = '0;
				clr_d   = clr_q + 1'b1;
				if (clr_q == TW'(TAPE_DEPTH - 1)) begin
					clr_d   = '0;
					state_d = clr_resp_q ? tmi_pkg::S_RESP : tmi_pkg::S_IDLE;
				end
			end

			tmi_pkg::S_IDLE: begin
				if (in_beat) begin
					emit_d = 1'b0;
					full_d = 1'b0;
					unique case (in_kind)
						tmi_pkg::KIND_LOAD: begin
							mod_go_d = 1'b1;
							state_d  = tmi_pkg::S_MOD;
						end
						tmi_pkg::KIND_APPEND: begin
							if (fill_q < IFW'(INPUT_DEPTH)) begin
								i_we   = 1'b1;
								fill_d = fill_q + 1'b1;
							end else begin
								full_d = 1'b1;
							end
							state_d = tmi_pkg::S_RESP;
						end
						tmi_pkg::KIND_STEP: begin
							// instruction fetch at pc; halted steps change nothing
							state_d = pc_halted ? tmi_pkg::S_RESP : tmi_pkg::S_DECODE;
						end
						tmi_pkg::KIND_RESTART: begin
							pc_d       = '0;
							tp_d       = '0;
							idx_d      = '0;
							cell_d     = '0;
							clr_d      = '0;
							clr_resp_d = 1'b1;
							state_d    = tmi_pkg::S_CLEAR;
						end
						default: state_d = tmi_pkg::S_RESP;
					endcase
				end
			end

			tmi_pkg::S_MOD: begin
				p_addr = mod_res;
				if (mod_done) begin
					p_we    = 1'b1;
					state_d = tmi_pkg::S_RESP;
				end
			end

			tmi_pkg::S_DECODE: begin
				pc_d    = pc_q + 1'b1;
				state_d = tmi_pkg::S_RESP;
				unique case (p_rdata)
					tmi_pkg::CH_PLUS: begin
						cell_d  = cell_q + 1'b1;
						t_we    = 1'b1;
						t_wdata = cell_q + 1'b1;
					end
					tmi_pkg::CH_MINUS: begin
						cell_d  = cell_q - 1'b1;
						t_we    = 1'b1;
						t_wdata = cell_q - 1'b1;
					end
					tmi_pkg::CH_LT: begin
						tp_d    = tp_dec;
						t_addr  = tp_dec;
						state_d = tmi_pkg::S_TREAD;
					end
					tmi_pkg::CH_GT: begin
						tp_d    = tp_inc;
						t_addr  = tp_inc;
						state_d = tmi_pkg::S_TREAD;
					end
					tmi_pkg::CH_DOT: begin
						emit_d = 1'b1;
					end
					tmi_pkg::CH_COMMA: begin
						if (idx_q < fill_q) begin
							i_addr  = IAW'(idx_q);
							idx_d   = idx_q + 1'b1;
							state_d = tmi_pkg::S_IREAD;
						end else begin
							cell_d  = '0;
							t_we    = 1'b1;
							t_wdata = '0;
						end
					end
					tmi_pkg::CH_LBR: begin
						if (cell_q == '0) begin
							pc_d    = pc_q;
							fwd_d   = 1'b1;
							depth_d = '0;
							scan_d  = pc_q + 1'b1;
							state_d = tmi_pkg::S_SCAN_RD;
						end
					end
					tmi_pkg::CH_RBR: begin
						if (cell_q != '0 && pc_q != '0) begin
							pc_d    = pc_q;
							fwd_d   = 1'b0;
							depth_d = '0;
							scan_d  = pc_q - 1'b1;
							state_d = tmi_pkg::S_SCAN_RD;
						end
					end
					default: begin
					end
				endcase
			end

			tmi_pkg::S_TREAD: begin
				cell_d  = t_rdata;
				state_d = tmi_pkg::S_RESP;
			end

			tmi_pkg::S_IREAD: begin
				cell_d  = i_rdata;
				t_we    = 1'b1;
				t_wdata = i_rdata;
				state_d = tmi_pkg::S_RESP;
			end

			tmi_pkg::S_SCAN_RD: begin
				p_addr = PAW'(scan_q);
				if (fwd_q && (LW'(scan_q) >= eff_len)) begin
					// no matching bracket: acts as a no-op
					pc_d    = pc_q + 1'b1;
					state_d = tmi_pkg::S_RESP;
				end else begin
					state_d = tmi_pkg::S_SCAN_CHK;
				end
			end

			tmi_pkg::S_SCAN_CHK: begin
				priority if ((fwd_q && p_rdata == tmi_pkg::CH_LBR)
				             || (!fwd_q && p_rdata == tmi_pkg::CH_RBR)) begin
					depth_d = depth_q + 1'b1;
				end else if ((fwd_q && p_rdata == tmi_pkg::CH_RBR)
				             || (!fwd_q && p_rdata == tmi_pkg::CH_LBR)) begin
					if (depth_q != '0) begin
						depth_d = depth_q - 1'b1;
					end
				end
				if (((fwd_q && p_rdata == tmi_pkg::CH_RBR)
				     || (!fwd_q && p_rdata == tmi_pkg::CH_LBR)) && depth_q == '0) begin
					// match: continue just after it
					pc_d    = scan_q + 1'b1;
					state_d = tmi_pkg::S_RESP;
				end else if (fwd_q) begin
					scan_d  = scan_q + 1'b1;
					state_d = tmi_pkg::S_SCAN_RD;
				end else if (scan_q == '0) begin
					// backward scan ran past address 0 without a match
					pc_d    = pc_q + 1'b1;
					state_d = tmi_pkg::S_RESP;
				end else begin
					scan_d  = scan_q - 1'b1;
					state_d = tmi_pkg::S_SCAN_RD;
				end
			end

			tmi_pkg::S_RESP: begin
				if (slot_free) begin
					clr_resp_d = 1'b0;
					state_d    = tmi_pkg::S_IDLE;
				end
			end

			default: state_d = tmi_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tmi_pkg::S_CLEAR;
			len_q      <= '0;
			pc_q       <= '0;
			tp_q       <= '0;
			idx_q      <= '0;
			fill_q     <= '0;
			cell_q     <= '0;
			depth_q    <= '0;
			fwd_q      <= 1'b0;
			emit_q     <= 1'b0;
			full_q     <= 1'b0;
			clr_resp_q <= 1'b0;
			clr_q      <= '0;
			mod_go_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			pc_q       <= pc_d;
			tp_q       <= tp_d;
			idx_q      <= idx_d;
			fill_q     <= fill_d;
			cell_q     <= cell_d;
			depth_q    <= depth_d;
			fwd_q      <= fwd_d;
			emit_q     <= emit_d;
			full_q     <= full_d;
			clr_resp_q <= clr_resp_d;
			clr_q      <= clr_d;
			mod_go_q   <= mod_go_d;
			if (cfg_we) begin
				len_q <= cfg_wdata;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		scan_q <= scan_d;
		if (in_beat) begin
			addr_q  <= prog_addr;
			pchar_q <= prog_char;
		end
		if (res_load) begin
			out_valid_q <= emit_q;
			out_byte_q  <= emit_q ? cell_q : '0;
			pc_now_q    <= pc_q;
			cell_now_q  <= cell_q;
			halted_q    <= pc_halted;
			full_out_q  <= full_q;
		end
	end

	assign res_valid   = res_valid_q;
	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign pc_now      = pc_now_q;
	assign cell_now    = cell_now_q;
	assign halted      = halted_q;
	assign buffer_full = full_out_q;

	// tape pointer stays on the tape for any depth
	a_tp_range: assert property (@(posedge clk) disable iff (!arst_n)
		tp_q < TW'(TAPE_DEPTH - 1) || tp_q == TW'(TAPE_DEPTH - 1))
		else $error("tape pointer off the tape");

	// input read index never runs ahead of the fill count
	a_idx_fill: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= fill_q && fill_q <= IFW'(INPUT_DEPTH))
		else $error("input index or fill count out of range");

	// a restart beat zeroes the machine and starts the tape clear
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && in_kind == tmi_pkg::KIND_RESTART
		|=> state_q == tmi_pkg::S_CLEAR && pc_q == '0 && cell_q == '0)
		else $error("restart did not clear state");

	// a result without an emitted byte carries a zero byte
	a_out_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !out_valid_q |-> out_byte_q == '0)
		else $error("out_byte set without output command");

	// a result load returns the sequencer to idle with the result valid
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> state_q == tmi_pkg::S_IDLE && res_valid_q)
		else $error("result load out of sequence");

endmodule

[rtl/core/tmi_ram.sv]
// generic single-port ram with registered read
module tmi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/tmi_addr_mod.sv]
// program address reduction modulo the program depth: reciprocal multiply, then one correction
module tmi_addr_mod #(
	parameter int DEPTH = tmi_pkg::DEF_PROG_DEPTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tmi_pkg::ADDR_W-1:0]  addr,
	output logic                        done,
	output logic [AW-1:0]               res
);

	localparam int AIW = tmi_pkg::ADDR_W;
	localparam int SH  = 24;
	localparam int MW  = AIW + SH;
	localparam int RW  = AIW + 1;
	// floor(2^SH / DEPTH): the quotient comes out exact or one low for any address
	localparam int RECIP = (2 ** SH) / DEPTH;
	// power-of-two depth or depth beyond the address range needs no reduction
	localparam bit MOD_FREE = (DEPTH >= (2 ** tmi_pkg::ADDR_W)) || ((DEPTH & (DEPTH - 1)) == 0);

	logic [MW-1:0]  prod_s1;
	logic [AIW-1:0] addr_s1;
	logic           v_s1;
	logic [RW-1:0]  rem_q;
	logic           done_q;
	logic [AIW-1:0] quot;
	logic [AIW-1:0] quot_x_depth;
	logic [RW-1:0]  rem_fix;

	assign quot         = prod_s1[SH +: AIW];
	assign quot_x_depth = AIW'(quot * AIW'(DEPTH));
	// remainder is below twice the depth, one compare and subtract finishes it
	assign rem_fix      = (rem_q >= RW'(DEPTH)) ? rem_q - RW'(DEPTH) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start && !MOD_FREE;
			done_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= MW'(addr) * MW'(RECIP);
			addr_s1 <= addr;
		end
		if (v_s1) begin
			rem_q <= {1'b0, addr_s1} - {1'b0, quot_x_depth};
		end
	end

	assign done = MOD_FREE ? start : done_q;
	assign res  = MOD_FREE ? AW'(addr) : AW'(rem_fix);

endmodule

[dv/tb.sv]
// testbench for the tape machine interpreter: directed and random runs
`timescale 1ns / 1ps

module tb;

	localparam int PDEPTH = tmi_pkg::DEF_PROG_DEPTH;
	localparam int TDEPTH = tmi_pkg::DEF_TAPE_DEPTH;
	localparam int IDEPTH = tmi_pkg::DEF_INPUT_DEPTH;
	localparam int AW     = tmi_pkg::ADDR_W;
	localparam int BW     = tmi_pkg::BYTE_W;
	localparam int LW     = tmi_pkg::LEN_W;
	// cycles with no beat on either side before the run is called hung;
	// covers the clear after reset, a restart and a long bracket skip with stalls
	localparam int HANG_LIMIT = 40000;

	typedef struct packed {
		tmi_pkg::kind_t k;
		logic [AW-1:0]  addr;
		logic [BW-1:0]  pchar;
		logic [BW-1:0]  ibyte;
	} cmd_t;

	typedef struct packed {
		logic          emit;
		logic [BW-1:0] emit_byte;
		logic [LW-1:0] pc;
		logic [BW-1:0] cur_val;
		logic          halt;
		logic          dropped;
	} status_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [LW-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	tmi_pkg::kind_t kind;
	logic [AW-1:0] prog_addr;
	logic [BW-1:0] prog_char;
	logic [BW-1:0] in_byte;
	logic res_valid;
	logic res_ready;
	logic out_valid;
	logic [BW-1:0] out_byte;
	logic [LW-1:0] pc_now;
	logic [BW-1:0] cell_now;
	logic halted;
	logic buffer_full;

	tape_machine_interpreter_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.prog_addr(prog_addr),
		.prog_char(prog_char),
		.in_byte(in_byte),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.out_valid(out_valid),
		.out_byte(out_byte),
		.pc_now(pc_now),
		.cell_now(cell_now),
		.halted(halted),
		.buffer_full(buffer_full)
	);

	// machine state as the testbench sees it
	logic [BW-1:0] m_prog [PDEPTH];
	logic [BW-1:0] m_tape [TDEPTH];
	logic [BW-1:0] m_inbuf [IDEPTH];
	int m_pc, m_tp, m_rd, m_fill, m_len;

	status_t status_q [$];
	int mismatch_count = 0;
	int sent = 0;
	int idle_cycles = 0;
	bit no_gaps = 0;

	always #1 clk = ~clk;

	function automatic int eff_len();
		return (m_len < PDEPTH) ? m_len : PDEPTH;
	endfunction

	// one instruction at pc; returns 1 when it emits
	function automatic bit run_instr();
		int len, pc, j, depth;
		logic [BW-1:0] c;
		bit emit;
		len = eff_len();
		pc = m_pc;
		emit = 0;
		if (pc >= len)
			return 0;
		c = m_prog[pc];
		case (c)
			tmi_pkg::CH_PLUS:  m_tape[m_tp] = m_tape[m_tp] + 8'd1;
			tmi_pkg::CH_MINUS: m_tape[m_tp] = m_tape[m_tp] - 8'd1;
			tmi_pkg::CH_LT:    m_tp = (m_tp == 0) ? TDEPTH - 1 : m_tp - 1;
			tmi_pkg::CH_GT:    m_tp = (m_tp + 1) % TDEPTH;
			tmi_pkg::CH_DOT:   emit = 1;
			tmi_pkg::CH_COMMA: begin
				if (m_rd < m_fill) begin
					m_tape[m_tp] = m_inbuf[m_rd];
					m_rd++;
				end else
					m_tape[m_tp] = '0;
			end
			tmi_pkg::CH_LBR: begin
				if (m_tape[m_tp] == 0) begin
					depth = 0;
					for (j = pc + 1; j < len; j++) begin
						if (m_prog[j] == tmi_pkg::CH_LBR)
							depth++;
						else if (m_prog[j] == tmi_pkg::CH_RBR) begin
							if (depth > 0)
								depth--;
							else begin
								pc = j;
								break;
							end
						end
					end
				end
			end
			tmi_pkg::CH_RBR: begin
				if (m_tape[m_tp] != 0) begin
					depth = 0;
					j = pc;
					while (j > 0) begin
						j--;
						if (m_prog[j] == tmi_pkg::CH_RBR)
							depth++;
						else if (m_prog[j] == tmi_pkg::CH_LBR) begin
							if (depth > 0)
								depth--;
							else begin
								pc = j;
								break;
							end
						end
					end
				end
			end
			default: ;
		endcase
		m_pc = pc + 1;
		return emit;
	endfunction

	// updates the machine state for one accepted beat and queues its status
	function automatic void predict_status(cmd_t cmd);
		status_t s;
		s = '0;
		case (cmd.k)
			tmi_pkg::KIND_LOAD: m_prog[cmd.addr] = cmd.pchar;
			tmi_pkg::KIND_APPEND: begin
				if (m_fill < IDEPTH) begin
					m_inbuf[m_fill] = cmd.ibyte;
					m_fill++;
				end else
					s.dropped = 1;
			end
			tmi_pkg::KIND_STEP: begin
				s.emit = run_instr();
				if (s.emit)
					s.emit_byte = m_tape[m_tp];
			end
			default: begin
				foreach (m_tape[i])
					m_tape[i] = '0;
				m_pc = 0;
				m_tp = 0;
				m_rd = 0;
			end
		endcase
		s.pc = m_pc[LW-1:0];
		s.cur_val = m_tape[m_tp];
		s.halt = (m_pc >= eff_len());
		status_q.push_back(s);
	endfunction

	task automatic send(cmd_t cmd);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= cmd.k;
		prog_addr <= cmd.addr;
		prog_char <= cmd.pchar;
		in_byte <= cmd.ibyte;
		do @(posedge clk); while (!in_ready);
		predict_status(cmd);
		sent++;
	endtask

	task automatic send_kind(tmi_pkg::kind_t k, int addr, int ch, int ib);
		cmd_t cmd;
		cmd.k = k;
		cmd.addr = addr[AW-1:0];
		cmd.pchar = ch[BW-1:0];
		cmd.ibyte = ib[BW-1:0];
		send(cmd);
	endtask

	// stop sending until every status beat is back, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (status_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_length(int len);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= len[LW-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		m_len = len & 32'h1FFF;
	endtask

	// mostly the eight commands, now and then any byte
	function automatic int pick_char();
		case ($urandom_range(0, 10))
			0: return tmi_pkg::CH_PLUS;
			1: return tmi_pkg::CH_MINUS;
			2: return tmi_pkg::CH_LT;
			3: return tmi_pkg::CH_GT;
			4: return tmi_pkg::CH_DOT;
			5: return tmi_pkg::CH_COMMA;
			6, 9: return tmi_pkg::CH_LBR;
			7, 10: return tmi_pkg::CH_RBR;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	// fixed program walking every command: pointer wrap, input read and
	// exhaustion, cell wrap both ways, forward skip, unmatched backward skip
	task automatic test_directed();
		logic [BW-1:0] prog [12];
		prog = '{tmi_pkg::CH_LT, tmi_pkg::CH_COMMA, tmi_pkg::CH_DOT, tmi_pkg::CH_GT,
			tmi_pkg::CH_MINUS, tmi_pkg::CH_PLUS, tmi_pkg::CH_LBR, tmi_pkg::CH_PLUS,
			tmi_pkg::CH_RBR, tmi_pkg::CH_COMMA, tmi_pkg::CH_PLUS, tmi_pkg::CH_RBR};
		send_kind(tmi_pkg::KIND_STEP, 0, 0, 0);        // length zero, already halted
		send_kind(tmi_pkg::KIND_LOAD, 4095, 255, 0);   // top address, all-ones byte
		foreach (prog[i])
			send_kind(tmi_pkg::KIND_LOAD, i, prog[i], 0);
		send_kind(tmi_pkg::KIND_APPEND, 0, 0, 8'hA5);
		set_length(12);
		repeat (18)
			send_kind(tmi_pkg::KIND_STEP, 0, 0, 0);
		send_kind(tmi_pkg::KIND_RESTART, 0, 0, 0);
		send_kind(tmi_pkg::KIND_STEP, 0, 0, 0);
	endtask

	// overflow the input buffer, then read its first byte after a restart
	task automatic test_buffer_full();
		repeat (IDEPTH + 4)
			send_kind(tmi_pkg::KIND_APPEND, 0, 0, $urandom_range(0, 255));
		send_kind(tmi_pkg::KIND_LOAD, 0, tmi_pkg::CH_COMMA, 0);
		send_kind(tmi_pkg::KIND_LOAD, 1, tmi_pkg::CH_DOT, 0);
		send_kind(tmi_pkg::KIND_LOAD, 2, tmi_pkg::CH_RBR, 0);
		set_length(3);
		send_kind(tmi_pkg::KIND_RESTART, 0, 0, 0);
		repeat (12)
			send_kind(tmi_pkg::KIND_STEP, 0, 0, 0);
	endtask

	// largest lengths; steps only at length zero since most of program memory is unwritten
	task automatic test_large_length();
		set_length(8191);
		send_kind(tmi_pkg::KIND_RESTART, 0, 0, 0);
		send_kind(tmi_pkg::KIND_LOAD, 4095, 0, 0);
		send_kind(tmi_pkg::KIND_APPEND, 0, 0, 0);
		set_length(PDEPTH);
		send_kind(tmi_pkg::KIND_LOAD, $urandom_range(0, 4095), $urandom_range(0, 255), 0);
		send_kind(tmi_pkg::KIND_RESTART, 0, 0, 0);
		set_length(0);
		send_kind(tmi_pkg::KIND_STEP, 0, 0, 0);
	endtask

	// short random programs run step by step with inputs and restarts mixed in
	task automatic test_random_programs(int total);
		int len, n;
		while (sent < total) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
			for (int a = 0; a < len; a++)
				send_kind(tmi_pkg::KIND_LOAD, a, pick_char(), 0);
			set_length(len);
			if ($urandom_range(0, 1))
				send_kind(tmi_pkg::KIND_RESTART, 0, 0, 0);
			n = $urandom_range(10, 40);
			repeat (n) begin
				case ($urandom_range(0, 19))
					0: send_kind(tmi_pkg::KIND_RESTART, 0, 0, 0);
					1, 2, 3: send_kind(tmi_pkg::KIND_APPEND, 0, 0, $urandom_range(0, 255));
					4: if (len > 0)
						send_kind(tmi_pkg::KIND_LOAD, $urandom_range(0, len - 1),
							pick_char(), 0);
					5: send_kind(tmi_pkg::KIND_LOAD, $urandom_range(0, 4095),
						$urandom_range(0, 255), 0);
					default: send_kind(tmi_pkg::KIND_STEP, 0, 0, 0);
				endcase
			end
		end
	endtask

	// result side: random stall per beat, then compare with the oldest prediction
	initial begin
		int stall;
		status_t got, want;
		res_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
			got = '{out_valid, out_byte, pc_now, cell_now, halted, buffer_full};
			if (status_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected status beat: %p", got);
			end else begin
				want = status_q.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"status mismatch: exp emit=%0b byte=%02h pc=%0d cell=%02h",
							" halt=%0b drop=%0b / act emit=%0b byte=%02h pc=%0d",
							" cell=%02h halt=%0b drop=%0b"},
							want.emit, want.emit_byte, want.pc, want.cur_val, want.halt,
							want.dropped, got.emit, got.emit_byte, got.pc, got.cur_val,
							got.halt, got.dropped);
				end
			end
		end
	end

	// hang watchdog: any beat on either side resets the count
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (res_valid && res_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= HANG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		kind = tmi_pkg::KIND_LOAD;
		prog_addr = '0;
		prog_char = '0;
		in_byte = '0;
		foreach (m_prog[i])
			m_prog[i] = '0;
		foreach (m_tape[i])
			m_tape[i] = '0;
		foreach (m_inbuf[i])
			m_inbuf[i] = '0;
		m_pc = 0;
		m_tp = 0;
		m_rd = 0;
		m_fill = 0;
		m_len = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_buffer_full();
		test_large_length();
		test_random_programs(1100);
		drain();

		if (mismatch_count == 0 && status_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[files.f]
rtl/core/tmi_pkg.sv
rtl/core/tmi_ram.sv
rtl/core/tmi_addr_mod.sv
rtl/core/tape_machine_interpreter_top.sv
dv/tb.sv
